// File: design/scm_pkg.sv
// Shared types and constants for the sorted change merge block.
package scm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TYPE_W = 2;
    localparam int ID_W   = 64;
    localparam int KIND_W = 3;
    localparam int TAG_W  = 16;

    localparam logic [KIND_W-1:0] KIND_NORMAL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        logic [KIND_W-1:0] kind;
        logic [TYPE_W-1:0] etype;
    } entry_t;

    typedef struct packed {
        logic              valid_element;
        logic [TYPE_W-1:0] etype;
        logic [ID_W-1:0]   id;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic              from_change;
        logic              last;
        logic              overflow;
    } result_t;

endpackage

// File: design/sorted_change_merge_top.sv
// Two-way merge of a sorted base stream and a sorted change stream.
// Input channel (in_valid/in_stall) carries items of both sides; op picks the
// side. Each side waits in a 16-entry queue held in a synchronous RAM.
// Output channel (out_valid/out_stall) carries merged elements, overflow
// beats and end markers. One output register sits on the output side.
// cfg_wr_en/cfg_wr_data set apply mode; write it only while the block is idle.
// Flow: an accepted item is written to its queue at the accepting edge, then
// both queue heads are fetched and merge steps run (equal keys pop both heads
// in one step, a dropped element still costs a step); the merge state then
// finds that nothing more can pop and the flush state closes the step.
// The registered RAM read sets the fetch state; the single compare-and-pop
// stage sets one merge step per cycle while no kept element waits on a
// stalled output register. A new item is taken only once the previous one
// is fully handled and the output register can take a beat.
// The last element of a step is held back in a pending register so the end
// flag can be set on it when both sides close.
// Reset clears queue pointers, fill counts, side-closed flags and apply mode;
// queue RAM contents are not cleared. A stalled receiver holds the output beat;
// the merge goes on until the next kept element needs the output register.
module sorted_change_merge_top
    import scm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic              has_element,
    input  logic [TYPE_W-1:0] elem_type,
    input  logic signed [ID_W-1:0] elem_id,
    input  logic [KIND_W-1:0] change_kind,
    input  logic [TAG_W-1:0]  elem_tag,
    input  logic              is_last,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              out_valid_element,
    output logic [TYPE_W-1:0] out_type,
    output logic signed [ID_W-1:0] out_id,
    output logic [KIND_W-1:0] out_change_kind,
    output logic [TAG_W-1:0]  out_tag,
    output logic              out_from_change,
    output logic              out_last,
    output logic              out_overflow
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MERGE,
        ST_FLUSH
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   base_head_reg, base_head_next;
    logic [PTR_W-1:0]   chg_head_reg, chg_head_next;
    logic [CNT_W-1:0]   base_fill_reg, base_fill_next;
    logic [CNT_W-1:0]   chg_fill_reg, chg_fill_next;
    logic               base_done_reg, base_done_next;
    logic               chg_done_reg, chg_done_next;
    logic               apply_reg, apply_next;
    logic               pend_valid_reg, pend_valid_next;
    result_t            pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg, out_data_next;

    entry_t             base_mem [QUEUE_DEPTH];
    entry_t             chg_mem  [QUEUE_DEPTH];
    entry_t             base_rd_reg, chg_rd_reg;

    logic               wr_base, wr_chg;
    logic [PTR_W-1:0]   wr_slot;
    entry_t             in_entry;

    logic               out_free;
    logic               in_fire;
    logic [CNT_W-1:0]   side_fill;
    logic [PTR_W-1:0]   side_head;
    logic [CNT_W:0]     slot_sum;

    logic               b_avail, c_avail;
    logic               b_lt, keys_eq;
    logic               pop_b, pop_c, sel_c;
    entry_t             sel_entry;
    logic               drop;
    logic               finishing;
    result_t            elem_res;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign in_entry = '{id: elem_id, tag: elem_tag, kind: change_kind, etype: elem_type};

    assign side_fill = op ? chg_fill_reg : base_fill_reg;
    assign side_head = op ? chg_head_reg : base_head_reg;
    assign slot_sum  = {1'b0, CNT_W'(side_head)} + {1'b0, side_fill};
    assign wr_slot   = (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                       ? PTR_W'(slot_sum - (CNT_W+1)'(QUEUE_DEPTH))
                       : PTR_W'(slot_sum);

    // head compare: type first, then signed id
    assign keys_eq = (base_rd_reg.etype == chg_rd_reg.etype) &&
                     (base_rd_reg.id == chg_rd_reg.id);
    assign b_lt    = (base_rd_reg.etype < chg_rd_reg.etype) ||
                     ((base_rd_reg.etype == chg_rd_reg.etype) &&
                      ($signed(base_rd_reg.id) < $signed(chg_rd_reg.id)));

    assign b_avail = (base_fill_reg != '0);
    assign c_avail = (chg_fill_reg != '0);

    always_comb
    begin
        pop_b = 1'b0;
        pop_c = 1'b0;
        sel_c = 1'b0;
        if (b_avail && c_avail)
        begin
            if (b_lt)
            begin
                pop_b = 1'b1;
            end
            else if (keys_eq)
            begin
                pop_b = 1'b1;
                pop_c = 1'b1;
                sel_c = 1'b1;
            end
            else
            begin
                pop_c = 1'b1;
                sel_c = 1'b1;
            end
        end
        else if (b_avail && chg_done_reg)
        begin
            pop_b = 1'b1;
        end
        else if (c_avail && base_done_reg)
        begin
            pop_c = 1'b1;
            sel_c = 1'b1;
        end
    end

    assign sel_entry = sel_c ? chg_rd_reg : base_rd_reg;
    assign drop      = apply_reg &&
                       (sel_entry.kind == KIND_DELETE || sel_entry.kind == KIND_REMOVE);

    assign elem_res = '{valid_element: 1'b1,
                        etype:         sel_entry.etype,
                        id:            sel_entry.id,
                        kind:          apply_reg ? KIND_NORMAL : sel_entry.kind,
                        tag:           sel_entry.tag,
                        from_change:   sel_c,
                        last:          1'b0,
                        overflow:      1'b0};

    assign finishing = base_done_reg && chg_done_reg &&
                       (base_fill_reg == '0) && (chg_fill_reg == '0);

    always_comb
    begin
        state_next      = state_reg;
        base_head_next  = base_head_reg;
        chg_head_next   = chg_head_reg;
        base_fill_next  = base_fill_reg;
        chg_fill_next   = chg_fill_reg;
        base_done_next  = base_done_reg;
        chg_done_next   = chg_done_reg;
        apply_next      = cfg_wr_en ? cfg_wr_data : apply_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        wr_base         = 1'b0;
        wr_chg          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !(op ? chg_done_reg : base_done_reg))
                begin
                    if (has_element)
                    begin
                        if (side_fill >= CNT_W'(QUEUE_DEPTH))
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_data_next.overflow = 1'b1;
                        end
                        else if (op)
                        begin
                            wr_chg        = 1'b1;
                            chg_fill_next = chg_fill_reg + 1'b1;
                        end
                        else
                        begin
                            wr_base        = 1'b1;
                            base_fill_next = base_fill_reg + 1'b1;
                        end
                    end
                    if (!has_element || is_last)
                    begin
                        if (op)
                        begin
                            chg_done_next = 1'b1;
                        end
                        else
                        begin
                            base_done_next = 1'b1;
                        end
                    end
                    state_next = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                state_next = ST_MERGE;
            end

            ST_MERGE:
            begin
                if (!(pop_b || pop_c))
                begin
                    state_next = ST_FLUSH;
                end
                else if (drop || !pend_valid_reg || out_free)
                begin
                    if (pop_b)
                    begin
                        base_head_next = ptr_inc(base_head_reg);
                        base_fill_next = base_fill_reg - 1'b1;
                    end
                    if (pop_c)
                    begin
                        chg_head_next = ptr_inc(chg_head_reg);
                        chg_fill_next = chg_fill_reg - 1'b1;
                    end
                    if (!drop)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = elem_res;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (pend_valid_reg || finishing)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_data_next = pend_reg;
                        end
                        else
                        begin
                            out_data_next = '0;
                        end
                        out_data_next.last = finishing;
                        pend_valid_next    = 1'b0;
                        if (finishing)
                        begin
                            base_done_next = 1'b0;
                            chg_done_next  = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_head_reg  <= '0;
            chg_head_reg   <= '0;
            base_fill_reg  <= '0;
            chg_fill_reg   <= '0;
            base_done_reg  <= 1'b0;
            chg_done_reg   <= 1'b0;
            apply_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            base_head_reg  <= base_head_next;
            chg_head_reg   <= chg_head_next;
            base_fill_reg  <= base_fill_next;
            chg_fill_reg   <= chg_fill_next;
            base_done_reg  <= base_done_next;
            chg_done_reg   <= chg_done_next;
            apply_reg      <= apply_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    // queue RAMs: read at the head that will be current next cycle
    always_ff @(posedge clk)
    begin
        if (wr_base)
        begin
            base_mem[wr_slot] <= in_entry;
        end
        base_rd_reg <= base_mem[base_head_next];
    end

    always_ff @(posedge clk)
    begin
        if (wr_chg)
        begin
            chg_mem[wr_slot] <= in_entry;
        end
        chg_rd_reg <= chg_mem[chg_head_next];
    end

    assign out_valid         = out_valid_reg;
    assign out_valid_element = out_data_reg.valid_element;
    assign out_type          = out_data_reg.etype;
    assign out_id            = out_data_reg.id;
    assign out_change_kind   = out_data_reg.kind;
    assign out_tag           = out_data_reg.tag;
    assign out_from_change   = out_data_reg.from_change;
    assign out_last          = out_data_reg.last;
    assign out_overflow      = out_data_reg.overflow;

endmodule

// File: design/scm_checker.sv
// Port-level checks for the sorted change merge block, bound to the top level.
module scm_checker
    import scm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              out_valid_element,
    input logic [TYPE_W-1:0] out_type,
    input logic [ID_W-1:0]   out_id,
    input logic [KIND_W-1:0] out_change_kind,
    input logic [TAG_W-1:0]  out_tag,
    input logic              out_from_change,
    input logic              out_last,
    input logic              out_overflow
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_id) && $stable(out_tag) &&
            $stable(out_type) && $stable(out_last) && $stable(out_overflow))
        else $error("output beat changed while stalled");

    // marker and overflow beats carry zeroed element fields
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_valid_element |-> out_type == '0 && out_id == '0 &&
            out_tag == '0 && out_change_kind == '0 && !out_from_change)
        else $error("marker beat with element fields set");

    // overflow beat never carries an element or the end flag
    a_ovf_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_overflow |-> !out_valid_element && !out_last)
        else $error("overflow beat carries element or end flag");

    // no new item is taken while an output beat is blocked
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output stalled");

endmodule

bind sorted_change_merge_top scm_checker u_scm_checker (.*);
